// ----- rtl/nts_pkg.sv -----
// Shared constants and codes for the nearest tagged position search.
`default_nettype none
package nts_pkg;

	localparam int MAX_LEN_DEF    = 1024;
	localparam int NUM_COLORS_DEF = 4;

	localparam int REQ_W       = 2;
	localparam int COLOR_W     = 2;
	localparam int QPOS_W      = 10;
	localparam int STATUS_W    = 2;
	localparam int DIST_W      = 10;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [REQ_W-1:0] {
		REQ_APPEND = 2'd0,
		REQ_QUERY  = 2'd1,
		REQ_CLEAR  = 2'd2
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE   = 2'd0,
		ST_VALID  = 2'd1,
		ST_ABSENT = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

endpackage
`default_nettype wire

// ----- rtl/nts_pos_mem.sv -----
// Position store: one write port and one registered read port.
`default_nettype none
module nts_pos_mem #(
	parameter int AW = 12,
	parameter int DW = 10
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data
);

	logic [DW-1:0] mem_q [2**AW];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ----- rtl/nearest_tagged_position_search.sv -----
// Nearest tagged position search: per-color position lists with binary-search queries.
// Append, clear and unused codes: the result is registered through S_DONE into the output register.
// Query: one store probe per cycle in a binary search over the color's list, then two
// neighbor reads and the output step in S_DONE.
// One item at a time; S_DONE holds the next item off while the output is still busy.
// Reset clears all list counts and the position counter; store contents stay undefined.
`default_nettype none
module nearest_tagged_position_search #(
	parameter int MAX_LEN    = nts_pkg::MAX_LEN_DEF,
	parameter int NUM_COLORS = nts_pkg::NUM_COLORS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [1:0] item_color, [11:2] query_position, [15:12] zero
	input  wire logic [nts_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// [1:0] req_type
	input  wire logic [nts_pkg::REQ_W-1:0]        s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// [9:0] distance, [15:10] zero
	output logic      [nts_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// [1:0] status
	output logic      [nts_pkg::STATUS_W-1:0]     m_axis_tuser
);
	import nts_pkg::*;

	localparam int NCOL = (NUM_COLORS < (1 << COLOR_W)) ? NUM_COLORS : (1 << COLOR_W);
	localparam int CW   = (NCOL > 1) ? $clog2(NCOL) : 1;
	localparam int IW   = $clog2(MAX_LEN);
	localparam int CNTW = $clog2(MAX_LEN + 1);
	localparam int DW   = (IW > QPOS_W) ? IW : QPOS_W;
	localparam int AW   = CW + IW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_BELOW,
		S_ABOVE,
		S_DONE
	} state_t;

	state_t                state_q;
	logic [CNTW-1:0]       counts_q [NCOL];
	logic [CNTW-1:0]       next_pos_q;
	logic [CNTW-1:0]       lo_q;
	logic [CNTW-1:0]       hi_q;
	logic [CNTW-1:0]       n_q;
	logic [IW-1:0]         mid_q;
	logic [CW-1:0]         color_q;
	logic [QPOS_W-1:0]     qpos_q;
	logic [DW-1:0]         below_d_q;
	status_t               res_status_q;
	logic [DIST_W-1:0]     res_dist_q;
	logic                  m_valid_q;
	status_t               m_status_q;
	logic [DIST_W-1:0]     m_dist_q;

	logic [COLOR_W-1:0]    s_color;
	logic [QPOS_W-1:0]     s_qpos;
	req_t                  s_req;
	logic                  accept;
	logic                  color_ok;
	logic [CW-1:0]         s_cidx;
	logic [CNTW-1:0]       s_count;
	logic                  app_ok;
	logic                  query_go;

	logic [IW-1:0]         rd_data;
	logic [IW-1:0]         rd_idx;
	logic [CW-1:0]         rd_color;
	logic                  wr_en;

	logic                  probe_lt;
	logic [CNTW-1:0]       lo_n;
	logic [CNTW-1:0]       hi_n;
	logic [CNTW-1:0]       mid_n;
	logic                  search_go;
	logic [CNTW-1:0]       lo_m1;
	logic [CNTW-1:0]       n_m1;
	logic [DW-1:0]         above_d;
	logic [DW-1:0]         dist_sel;
	logic                  out_free;

	assign s_color  = s_axis_tdata[COLOR_W-1:0];
	assign s_qpos   = s_axis_tdata[COLOR_W+QPOS_W-1:COLOR_W];
	assign s_req    = req_t'(s_axis_tuser);
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign color_ok = ({1'b0, s_color} < (COLOR_W + 1)'(NCOL));
	assign s_cidx   = CW'(s_color);
	assign s_count  = counts_q[s_cidx];
	assign app_ok   = color_ok && (next_pos_q != CNTW'(MAX_LEN));
	assign query_go = (s_req == REQ_QUERY) && color_ok && (s_count != '0);
	assign wr_en    = accept && (s_req == REQ_APPEND) && app_ok;
	assign out_free = !m_valid_q || m_axis_tready;

	assign probe_lt  = (DW'(rd_data) < DW'(qpos_q));
	assign lo_n      = probe_lt ? (CNTW'(mid_q) + CNTW'(1)) : lo_q;
	assign hi_n      = probe_lt ? hi_q : CNTW'(mid_q);
	assign mid_n     = lo_n + ((hi_n - lo_n) >> 1);
	assign search_go = (lo_n < hi_n);
	assign lo_m1     = lo_n - CNTW'(1);
	assign n_m1      = n_q - CNTW'(1);

	always_comb begin
		rd_color = color_q;
		rd_idx   = mid_q;
		unique case (state_q)
			S_IDLE: begin
				rd_color = s_cidx;
				rd_idx   = IW'(s_count >> 1);
			end
			S_SEARCH: begin
				if (search_go) begin
					rd_idx = mid_n[IW-1:0];
				end else if (lo_n == '0) begin
					rd_idx = '0;
				end else begin
					rd_idx = lo_m1[IW-1:0];
				end
			end
			S_BELOW: begin
				rd_idx = (lo_q == n_q) ? n_m1[IW-1:0] : lo_q[IW-1:0];
			end
			default: begin
				rd_idx = mid_q;
			end
		endcase
	end

	always_comb begin
		above_d = DW'(rd_data) - DW'(qpos_q);
		if (lo_q != n_q && DW'(rd_data) == DW'(qpos_q)) begin
			dist_sel = '0;
		end else if (lo_q == '0) begin
			dist_sel = above_d;
		end else if (lo_q == n_q) begin
			dist_sel = below_d_q;
		end else begin
			dist_sel = (below_d_q < above_d) ? below_d_q : above_d;
		end
	end

	nts_pos_mem #(
		.AW(AW),
		.DW(IW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr ({s_cidx, s_count[IW-1:0]}),
		.wr_data (next_pos_q[IW-1:0]),
		.rd_addr ({rd_color, rd_idx}),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			for (int i = 0; i < NCOL; i++) begin
				counts_q[i] <= '0;
			end
			next_pos_q   <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			n_q          <= '0;
			mid_q        <= '0;
			color_q      <= '0;
			qpos_q       <= '0;
			below_d_q    <= '0;
			res_status_q <= ST_DONE;
			res_dist_q   <= '0;
			m_valid_q    <= 1'b0;
			m_status_q   <= ST_DONE;
			m_dist_q     <= '0;
		end else begin
			if (m_valid_q && m_axis_tready && state_q != S_DONE) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						color_q    <= s_cidx;
						qpos_q     <= s_qpos;
						res_dist_q <= '0;
						state_q    <= query_go ? S_SEARCH : S_DONE;
						case (s_req)
							REQ_APPEND: begin
								if (app_ok) begin
									counts_q[s_cidx] <= s_count + CNTW'(1);
									next_pos_q       <= next_pos_q + CNTW'(1);
									res_status_q     <= ST_DONE;
								end else begin
									res_status_q <= ST_FULL;
								end
							end
							REQ_QUERY: begin
								if (!query_go) begin
									res_status_q <= ST_ABSENT;
								end else begin
									lo_q  <= '0;
									hi_q  <= s_count;
									n_q   <= s_count;
									mid_q <= IW'(s_count >> 1);
								end
							end
							REQ_CLEAR: begin
								for (int i = 0; i < NCOL; i++) begin
									counts_q[i] <= '0;
								end
								next_pos_q   <= '0;
								res_status_q <= ST_DONE;
							end
							default: begin
								res_status_q <= ST_DONE;
							end
						endcase
					end
				end
				S_SEARCH: begin
					lo_q <= lo_n;
					hi_q <= hi_n;
					if (search_go) begin
						mid_q <= mid_n[IW-1:0];
					end else begin
						state_q <= S_BELOW;
					end
				end
				S_BELOW: begin
					below_d_q <= DW'(qpos_q) - DW'(rd_data);
					state_q   <= S_ABOVE;
				end
				S_ABOVE: begin
					res_status_q <= ST_VALID;
					res_dist_q   <= dist_sel[DIST_W-1:0];
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						m_valid_q  <= 1'b1;
						m_status_q <= res_status_q;
						m_dist_q   <= res_dist_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - DIST_W){1'b0}}, m_dist_q};

endmodule
`default_nettype wire
